>>> sv/baro_sensor_compensation_avg_macros.svh
// Assertion macros for the barometric compensation block.
`ifndef BARO_SENSOR_COMPENSATION_AVG_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_AVG_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BSC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> sv/bsc_pkg.sv
// Shared types and constants for the barometric compensation block.
package bsc_pkg;
    localparam logic [31:0] B6_OFS = 32'd4000;
    localparam logic [31:0] P_K1 = 32'd3038;
    localparam logic [31:0] P_K2 = 32'hFFFF_E343;
    localparam logic [31:0] P_K3 = 32'd3791;
    localparam logic [31:0] P_SCALE = 32'd50000;
    localparam logic [31:0] P_HALF = 32'd32768;
    localparam logic [2:0] REG_AC1 = 3'd0;
    localparam logic [2:0] REG_AC2 = 3'd1;
    localparam logic [2:0] REG_AC3 = 3'd2;
    localparam logic [2:0] REG_AC4 = 3'd3;
    localparam logic [2:0] REG_TCAL = 3'd4;
    localparam logic [2:0] REG_TCRV = 3'd5;
    localparam logic [2:0] REG_PCRV = 3'd6;
    localparam logic [2:0] REG_OSS = 3'd7;
    typedef struct packed {
        logic start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;
    typedef struct packed {
        logic busy;
        logic done;
        logic [31:0] quo;
    } div_rsp_t;
endpackage

>>> sv/bsc_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module bsc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsc_pkg::div_req_t req,
    output bsc_pkg::div_rsp_t rsp
);
    logic [31:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (req.start) begin
            q_next = req.num;
            r_next = '0;
            d_next = req.den;
            cnt_next = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = q_reg;
endmodule

>>> sv/baro_sensor_compensation_avg.sv
// Barometric sensor compensation with running mean over the last AVG_DEPTH values per kind.
// Top level of the barometric compensation block.
// One reading is taken at a time: s_tready is low from acceptance until its result beat
// has been handed over, and rises again once the beat is taken. The work is done by
// the shared 32x32 multiplier, the bit-serial 32-step divider (at most one pass per
// reading), a ring sweep that forms the sum, and a reciprocal multiply with up to three
// compare-and-subtract steps that divides the sum by AVG_DEPTH.
// Ring valid bits reset to clear, so unwritten entries read as zero.
module baro_sensor_compensation_avg #(
    parameter int AVG_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_reading
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // instant_value, mean_value
    output logic [1:0]  m_tuser,   // result_kind, divide_fault
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "baro_sensor_compensation_avg_macros.svh"
    localparam int SW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CW = $clog2(AVG_DEPTH + 1);
    localparam int LG = $clog2(AVG_DEPTH);
    localparam int SUMW = 32 + CW;
    localparam logic [31:0] DEPTH32 = 32'(AVG_DEPTH);
    localparam logic [63:0] RECIP64 = (64'd1 << (31 + LG)) / 64'(AVG_DEPTH);
    localparam logic [31:0] RECIP = RECIP64[31:0];

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T1   = 5'd1;
    localparam logic [4:0] S_T2   = 5'd2;
    localparam logic [4:0] S_T3   = 5'd3;
    localparam logic [4:0] S_TDV  = 5'd4;
    localparam logic [4:0] S_P1   = 5'd5;
    localparam logic [4:0] S_P2   = 5'd6;
    localparam logic [4:0] S_P3   = 5'd7;
    localparam logic [4:0] S_P4   = 5'd8;
    localparam logic [4:0] S_P5   = 5'd9;
    localparam logic [4:0] S_P6   = 5'd10;
    localparam logic [4:0] S_P7   = 5'd11;
    localparam logic [4:0] S_P8   = 5'd12;
    localparam logic [4:0] S_PDV  = 5'd13;
    localparam logic [4:0] S_Q1   = 5'd14;
    localparam logic [4:0] S_Q2   = 5'd15;
    localparam logic [4:0] S_Q3   = 5'd16;
    localparam logic [4:0] S_Q4   = 5'd17;
    localparam logic [4:0] S_PUSH = 5'd18;
    localparam logic [4:0] S_SUM  = 5'd19;
    localparam logic [4:0] S_MDV  = 5'd20;
    localparam logic [4:0] S_OUT  = 5'd21;
    localparam logic [4:0] S_B4   = 5'd22;
    localparam logic [4:0] S_MRM  = 5'd23;
    localparam logic [4:0] S_MFX  = 5'd24;

    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg;
    logic [31:0] tcal_reg, tcrv_reg, pcrv_reg;
    logic [1:0]  oss_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_reg <= 16'd408;
            ac2_reg <= 16'hFFB8;
            ac3_reg <= 16'hC7D1;
            ac4_reg <= 16'd32741;
            tcal_reg <= 32'd2146785905;
            tcrv_reg <= 32'd3724086068;
            pcrv_reg <= 32'd405667844;
            oss_reg <= 2'd3;
        end else if (wr_en) begin
            case (paddr[4:2])
                bsc_pkg::REG_AC1:  ac1_reg <= pwdata[15:0];
                bsc_pkg::REG_AC2:  ac2_reg <= pwdata[15:0];
                bsc_pkg::REG_AC3:  ac3_reg <= pwdata[15:0];
                bsc_pkg::REG_AC4:  ac4_reg <= pwdata[15:0];
                bsc_pkg::REG_TCAL: tcal_reg <= pwdata;
                bsc_pkg::REG_TCRV: tcrv_reg <= pwdata;
                bsc_pkg::REG_PCRV: pcrv_reg <= pwdata;
                bsc_pkg::REG_OSS:  oss_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            bsc_pkg::REG_AC1:  prdata = {16'd0, ac1_reg};
            bsc_pkg::REG_AC2:  prdata = {16'd0, ac2_reg};
            bsc_pkg::REG_AC3:  prdata = {16'd0, ac3_reg};
            bsc_pkg::REG_AC4:  prdata = {16'd0, ac4_reg};
            bsc_pkg::REG_TCAL: prdata = tcal_reg;
            bsc_pkg::REG_TCRV: prdata = tcrv_reg;
            bsc_pkg::REG_PCRV: prdata = pcrv_reg;
            default:           prdata = {30'd0, oss_reg};
        endcase
    end

    // rings, read one entry per cycle during the sum sweep
    logic [31:0] ring_t [AVG_DEPTH];
    logic [31:0] ring_p [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] vld_t_reg, vld_p_reg;
    logic [SW-1:0] tslot_reg, pslot_reg, idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] rd_t, rd_p;
    logic [SUMW-1:0] sum_reg, sum_all, mag_reg;
    logic [31:0] rem_reg;

    logic [4:0]  st_reg;
    logic        mode_reg, fault_reg;
    logic [23:0] raw_reg;
    logic [31:0] b5_reg, a_reg, b_reg, c_reg, d_reg, e_reg, val_reg, mean_reg;
    logic [31:0] b6, mul_x, mul_y, prod, sq_reg;
    logic [63:0] prod_w;
    logic        neg_reg, ovm_reg;
    bsc_pkg::div_req_t dreq;
    bsc_pkg::div_rsp_t drsp;

    bsc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction
    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction
    function automatic logic [31:0] absv(input logic [31:0] v);
        absv = v[31] ? 32'd0 - v : v;
    endfunction

    assign b6 = b5_reg - bsc_pkg::B6_OFS;
    assign prod_w = {32'd0, mul_x} * {32'd0, mul_y};
    assign prod = prod_w[31:0];

    // operand select for the shared multiplier
    always_comb begin
        mul_x = a_reg;
        mul_y = b_reg;
        case (st_reg)
            S_T1: begin mul_x = {16'd0, raw_reg[15:0]} - {16'd0, tcal_reg[15:0]};
                mul_y = {16'd0, tcal_reg[31:16]}; end
            S_P1: begin mul_x = b6; mul_y = b6; end
            S_P2: begin mul_x = sx(pcrv_reg[15:0]); mul_y = sq_reg; end
            S_P3: begin mul_x = sx(ac2_reg); mul_y = b6; end
            S_P4: begin mul_x = sx(ac3_reg); mul_y = b6; end
            S_P5: begin mul_x = sx(pcrv_reg[31:16]); mul_y = sq_reg; end
            S_P6: begin mul_x = {16'd0, ac4_reg}; mul_y = a_reg; end
            S_P7: begin mul_x = c_reg; mul_y = bsc_pkg::P_SCALE >> oss_reg; end
            S_Q1: begin mul_x = asr(val_reg, 5'd8); mul_y = asr(val_reg, 5'd8); end
            S_Q2: begin mul_x = a_reg; mul_y = bsc_pkg::P_K1; end
            S_Q3: begin mul_x = bsc_pkg::P_K2; mul_y = val_reg; end
            S_MDV: begin mul_x = 32'(mag_reg >> LG); mul_y = RECIP; end
            S_MRM: begin mul_x = mean_reg; mul_y = DEPTH32; end
            default: ;
        endcase
    end

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata = {mean_reg, val_reg};
    assign m_tuser = {fault_reg, mode_reg};

    always_ff @(posedge aclk) begin
        if (st_reg == S_PUSH) begin
            if (!mode_reg) ring_t[tslot_reg] <= val_reg;
            else ring_p[pslot_reg] <= val_reg;
        end
        rd_t <= vld_t_reg[idx_reg] ? ring_t[idx_reg] : '0;
        rd_p <= vld_p_reg[idx_reg] ? ring_p[idx_reg] : '0;
    end

    logic [31:0] b3, up, ent;
    assign b3 = 32'($signed((((sx(ac1_reg) << 2) + c_reg) << oss_reg) + 32'd2) / 4);
    assign up = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});
    assign ent = mode_reg ? rd_p : rd_t;
    assign sum_all = sum_reg + {{CW{ent[31]}}, ent};

    always_ff @(posedge aclk) begin
        dreq.start <= 1'b0;
        if (!aresetn) begin
            st_reg <= S_IDLE;
            b5_reg <= '0;
            tslot_reg <= '0;
            pslot_reg <= '0;
            vld_t_reg <= '0;
            vld_p_reg <= '0;
        end else begin
            case (st_reg)
                S_IDLE: if (s_tvalid) begin
                    mode_reg <= s_tuser;
                    raw_reg <= s_tdata;
                    fault_reg <= 1'b0;
                    st_reg <= s_tuser ? S_P1 : S_T1;
                end
                S_T1: begin a_reg <= asr(prod, 5'd15); st_reg <= S_T2; end
                S_T2: begin
                    b_reg <= a_reg + sx(tcrv_reg[15:0]);
                    st_reg <= S_T3;
                end
                S_T3: if (b_reg == 0) begin
                    fault_reg <= 1'b1; val_reg <= '0; st_reg <= S_PUSH;
                end else begin
                    c_reg <= sx(tcrv_reg[31:16]) << 11;
                    neg_reg <= tcrv_reg[31] ^ b_reg[31];
                    dreq.start <= 1'b1;
                    dreq.num <= absv(sx(tcrv_reg[31:16]) << 11);
                    dreq.den <= absv(b_reg);
                    st_reg <= S_TDV;
                end
                S_TDV: if (drsp.done) begin
                    b5_reg <= a_reg + (neg_reg ? 32'd0 - drsp.quo : drsp.quo);
                    val_reg <= asr(a_reg + (neg_reg ? 32'd0 - drsp.quo : drsp.quo)
                                   + 32'd8, 5'd4);
                    st_reg <= S_PUSH;
                end
                S_P1: begin sq_reg <= asr(prod, 5'd12); st_reg <= S_P2; end
                S_P2: begin d_reg <= asr(prod, 5'd11); st_reg <= S_P3; end
                S_P3: begin c_reg <= d_reg + asr(prod, 5'd11); st_reg <= S_P4; end
                S_P4: begin
                    e_reg <= b3;
                    d_reg <= asr(prod, 5'd13);
                    st_reg <= S_P5;
                end
                S_P5: begin
                    a_reg <= asr(d_reg + asr(prod, 5'd16) + 32'd2, 5'd2) + bsc_pkg::P_HALF;
                    c_reg <= up - e_reg;
                    st_reg <= S_P6;
                end
                S_P6: begin d_reg <= prod >> 15; st_reg <= S_P7; end
                S_P7: begin e_reg <= prod; st_reg <= S_B4; end
                S_B4: if (d_reg == 0) begin
                    fault_reg <= 1'b1; val_reg <= '0; st_reg <= S_PUSH;
                end else begin
                    ovm_reg <= e_reg[31];
                    dreq.start <= 1'b1;
                    dreq.num <= e_reg[31] ? e_reg : e_reg << 1;
                    dreq.den <= d_reg;
                    st_reg <= S_PDV;
                end
                S_PDV: if (drsp.done) begin
                    val_reg <= ovm_reg ? drsp.quo << 1 : drsp.quo;
                    st_reg <= S_Q1;
                end
                S_Q1: begin a_reg <= prod; st_reg <= S_Q2; end
                S_Q2: begin d_reg <= asr(prod, 5'd16); st_reg <= S_Q3; end
                S_Q3: begin d_reg <= d_reg + asr(prod, 5'd16); st_reg <= S_Q4; end
                S_Q4: begin
                    val_reg <= val_reg + asr(d_reg + bsc_pkg::P_K3, 5'd4);
                    st_reg <= S_PUSH;
                end
                S_PUSH: begin
                    if (!mode_reg) begin
                        vld_t_reg[tslot_reg] <= 1'b1;
                        tslot_reg <= (32'(tslot_reg) >= AVG_DEPTH - 1) ? '0 : tslot_reg + 1'b1;
                    end else begin
                        vld_p_reg[pslot_reg] <= 1'b1;
                        pslot_reg <= (32'(pslot_reg) >= AVG_DEPTH - 1) ? '0 : pslot_reg + 1'b1;
                    end
                    idx_reg <= '0;
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    st_reg <= S_SUM;
                end
                S_SUM: begin
                    // read data is registered and arrives in the cycle after its index
                    if (cnt_reg != 0) sum_reg <= sum_all;
                    if (32'(cnt_reg) == AVG_DEPTH) begin
                        st_reg <= S_MDV;
                        neg_reg <= sum_all[SUMW-1];
                        mag_reg <= sum_all[SUMW-1] ? '0 - sum_all : sum_all;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (32'(idx_reg) < AVG_DEPTH - 1) idx_reg <= idx_reg + 1'b1;
                    end
                end
                // quotient estimate is low by at most three
                S_MDV: begin mean_reg <= prod_w[62:31]; st_reg <= S_MRM; end
                S_MRM: begin rem_reg <= mag_reg[31:0] - prod; st_reg <= S_MFX; end
                S_MFX: if (rem_reg >= DEPTH32) begin
                    rem_reg <= rem_reg - DEPTH32;
                    mean_reg <= mean_reg + 32'd1;
                end else begin
                    mean_reg <= neg_reg ? 32'd0 - mean_reg : mean_reg;
                    st_reg <= S_OUT;
                end
                S_OUT: if (m_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `BSC_ASSERT_IMPL(a_rdy_out, aclk, aresetn, m_tvalid, !s_tready)
    `BSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BSC_ASSERT_IMPL(a_div_idle, aclk, aresetn, s_tready, !drsp.busy)
endmodule
